@@ hdl/slm_pkg.sv @@
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types and constants for the sorted list merge unit.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int unsigned LIST_DEPTH_DEF  = 32;
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned POS_W           = 6;
  localparam int unsigned REQ_W           = 2;

  // request codes; code 3 is ignored
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_FIRST  = 2'd0,
    REQ_LOAD_SECOND = 2'd1,
    REQ_RUN         = 2'd2
  } req_t;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] merged_value;
    logic [POS_W-1:0]         position;
    logic                     last_flag;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_SETTLE,
    ST_EMIT
  } state_t;

  // sequencer strobes toward the datapath
  typedef struct packed {
    logic first_we;
    logic second_we;
    logic seq_we;
    logic out_load;
    logic out_last;
  } slm_ctl_t;

endpackage

@@ hdl/slm_ram.sv @@
// ----------------------------------------------------------------------------
// slm_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module slm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/slm_pick.sv @@
// ----------------------------------------------------------------------------
// slm_pick
// Shared compare/select unit: picks the tail element that goes last.
// ----------------------------------------------------------------------------
module slm_pick #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned CNT_W       = 6
) (
  input  logic [VALUE_WIDTH-1:0] first_val,
  input  logic [VALUE_WIDTH-1:0] second_val,
  input  logic [CNT_W-1:0]       first_left,
  input  logic [CNT_W-1:0]       second_left,
  output logic                   take_second,
  output logic [VALUE_WIDTH-1:0] pick_val
);

  // first list wins ties; once second list is empty, first keeps its order
  always_comb begin
    take_second = (second_left != '0) &&
                  ((first_left == '0) || ($signed(first_val) < $signed(second_val)));
    pick_val    = take_second ? second_val : first_val;
  end

endmodule

@@ hdl/slm_seq.sv @@
// ----------------------------------------------------------------------------
// slm_seq
// Sequencer: list counts, merge/emit state machine and RAM addressing.
// ----------------------------------------------------------------------------
module slm_seq
  import slm_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
  localparam int unsigned CNT_W     = $clog2(LIST_DEPTH + 1),
  localparam int unsigned IDX_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int unsigned SEQ_IDX_W = $clog2(2 * LIST_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     req_type,
  input  logic                 out_free,
  input  logic                 take_second,
  output slm_ctl_t             ctl,
  output logic [IDX_W-1:0]     first_waddr,
  output logic [IDX_W-1:0]     second_waddr,
  output logic [IDX_W-1:0]     first_raddr,
  output logic [IDX_W-1:0]     second_raddr,
  output logic [CNT_W-1:0]     first_left,
  output logic [CNT_W-1:0]     second_left,
  output logic [SEQ_IDX_W-1:0] seq_waddr,
  output logic [SEQ_IDX_W-1:0] seq_raddr,
  output logic [SEQ_IDX_W-1:0] emit_pos
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     first_cnt_r, first_cnt_nxt;
  logic [CNT_W-1:0]     second_cnt_r, second_cnt_nxt;
  logic [CNT_W-1:0]     m_r, m_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  logic [SEQ_IDX_W-1:0] pos_r, pos_nxt;
  logic [SEQ_IDX_W-1:0] last_pos_r, last_pos_nxt;
  logic                 accept;
  logic [CNT_W:0]       mn_sum;
  logic [CNT_W:0]       mn_dst;
  logic [CNT_W:0]       cnt_sum;
  logic [CNT_W:0]       cnt_last;
  logic [CNT_W-1:0]     m_dec;
  logic [CNT_W-1:0]     n_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      m_r          <= '0;
      n_r          <= '0;
      pos_r        <= '0;
      last_pos_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      m_r          <= m_nxt;
      n_r          <= n_nxt;
      pos_r        <= pos_nxt;
      last_pos_r   <= last_pos_nxt;
    end
  end

  always_comb begin
    in_ready       = (state_r == ST_IDLE);
    accept         = in_valid && in_ready;
    mn_sum         = {1'b0, m_r} + {1'b0, n_r};
    mn_dst         = mn_sum - 1'b1;
    cnt_sum        = {1'b0, first_cnt_r} + {1'b0, second_cnt_r};
    cnt_last       = cnt_sum - 1'b1;

    state_nxt      = state_r;
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    m_nxt          = m_r;
    n_nxt          = n_r;
    pos_nxt        = pos_r;
    last_pos_nxt   = last_pos_r;
    ctl            = '0;

    case (state_r)
      ST_IDLE: begin
        // keep the tail reads primed on the current counts
        m_nxt = first_cnt_r;
        n_nxt = second_cnt_r;
        if (accept) begin
          case (req_type)
            REQ_LOAD_FIRST: begin
              if (first_cnt_r < FULL) begin
                ctl.first_we  = 1'b1;
                first_cnt_nxt = first_cnt_r + 1'b1;
              end
            end
            REQ_LOAD_SECOND: begin
              if (second_cnt_r < FULL) begin
                ctl.second_we  = 1'b1;
                second_cnt_nxt = second_cnt_r + 1'b1;
              end
            end
            REQ_RUN: begin
              first_cnt_nxt  = '0;
              second_cnt_nxt = '0;
              last_pos_nxt   = cnt_last[SEQ_IDX_W-1:0];
              if (cnt_sum != '0) begin
                state_nxt = ST_MERGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MERGE: begin
        ctl.seq_we = 1'b1;
        if (take_second) begin
          n_nxt = n_r - 1'b1;
        end else begin
          m_nxt = m_r - 1'b1;
        end
        if (mn_dst == '0) begin
          state_nxt = ST_SETTLE;
          pos_nxt   = '0;
        end
      end
      ST_SETTLE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_last = (pos_r == last_pos_r);
          if (pos_r == last_pos_r) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    m_dec        = m_nxt - 1'b1;
    n_dec        = n_nxt - 1'b1;
    first_raddr  = m_dec[IDX_W-1:0];
    second_raddr = n_dec[IDX_W-1:0];
    first_waddr  = first_cnt_r[IDX_W-1:0];
    second_waddr = second_cnt_r[IDX_W-1:0];
    first_left   = m_r;
    second_left  = n_r;
    seq_waddr    = mn_dst[SEQ_IDX_W-1:0];
    seq_raddr    = pos_nxt;
    emit_pos     = pos_r;
  end

endmodule

@@ hdl/sorted_list_merge_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_list_merge_unit
// Merges two loaded lists of signed values and streams the merged sequence.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                         | Moves
//  --------+-------------------------------+------------------------------------
//  input   | in_valid, in_ready, in_data   | load into first/second list, or run
//  output  | out_valid, out_ready, out_data| one merged element per item
//
//  Flow: a load item leaves in_ready high. A run with m + n elements takes m + n
//  merge steps (one shared compare/select per element, written back to front
//  into the sequence RAM), a settle state for the RAM read, then one result
//  per cycle while out_ready is high; in_ready stays low until the last
//  result is in the output register, and a stalled output holds the pointer.
//  Reset (rst_n low, synchronous) clears counts and sequencer, not list storage.
//
module sorted_list_merge_unit
  import slm_pkg::*;
#(
  parameter int unsigned LIST_DEPTH  = LIST_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int unsigned CNT_W     = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned SEQ_DEPTH = 2 * LIST_DEPTH;
  localparam int unsigned SEQ_IDX_W = $clog2(SEQ_DEPTH);

  slm_ctl_t               ctl;
  logic [IDX_W-1:0]       first_waddr, second_waddr;
  logic [IDX_W-1:0]       first_raddr, second_raddr;
  logic [CNT_W-1:0]       first_left, second_left;
  logic [SEQ_IDX_W-1:0]   seq_waddr, seq_raddr, emit_pos;
  logic [VALUE_WIDTH-1:0] in_val_w;
  logic [VALUE_WIDTH-1:0] first_rd, second_rd, seq_rd;
  logic [VALUE_WIDTH-1:0] pick_val;
  logic                   take_second;
  logic                   out_free;
  logic [DATA_W-1:0]      emit_val;
  logic                   out_valid_r;
  out_item_t              out_data_r;

  // keep the low VALUE_WIDTH bits of the load value (zero above 32 bits)
  always_comb begin
    in_val_w = '0;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      in_val_w[i] = (i < DATA_W) ? in_data.value[(i < DATA_W) ? i : DATA_W - 1] : 1'b0;
    end
  end

  // sign-extend (or truncate) the stored element back to the output field
  always_comb begin
    emit_val = '0;
    for (int i = 0; i < DATA_W; i++) begin
      emit_val[i] = seq_rd[(i < VALUE_WIDTH) ? i : VALUE_WIDTH - 1];
    end
  end

  slm_seq #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (in_data.req_type),
    .out_free     (out_free),
    .take_second  (take_second),
    .ctl          (ctl),
    .first_waddr  (first_waddr),
    .second_waddr (second_waddr),
    .first_raddr  (first_raddr),
    .second_raddr (second_raddr),
    .first_left   (first_left),
    .second_left  (second_left),
    .seq_waddr    (seq_waddr),
    .seq_raddr    (seq_raddr),
    .emit_pos     (emit_pos)
  );

  slm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_first_ram (
    .clk   (clk),
    .we    (ctl.first_we),
    .waddr (first_waddr),
    .wdata (in_val_w),
    .raddr (first_raddr),
    .rdata (first_rd)
  );

  slm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (LIST_DEPTH)
  ) u_second_ram (
    .clk   (clk),
    .we    (ctl.second_we),
    .waddr (second_waddr),
    .wdata (in_val_w),
    .raddr (second_raddr),
    .rdata (second_rd)
  );

  // one compare/select per merge cycle, shared across the whole run
  slm_pick #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .CNT_W       (CNT_W)
  ) u_pick (
    .first_val   (first_rd),
    .second_val  (second_rd),
    .first_left  (first_left),
    .second_left (second_left),
    .take_second (take_second),
    .pick_val    (pick_val)
  );

  // merged sequence in final order
  slm_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (SEQ_DEPTH)
  ) u_seq_ram (
    .clk   (clk),
    .we    (ctl.seq_we),
    .waddr (seq_waddr),
    .wdata (pick_val),
    .raddr (seq_raddr),
    .rdata (seq_rd)
  );

  // output register: loads whenever empty or being drained
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r.merged_value <= emit_val;
      out_data_r.position     <= POS_W'(emit_pos);
      out_data_r.last_flag    <= ctl.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/slm_chk.sv @@
// ----------------------------------------------------------------------------
// slm_chk
// Port-level checker for the sorted list merge unit, bound to the top level.
// ----------------------------------------------------------------------------
module slm_chk
  import slm_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // ready only drops after an accepted item (a run)
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid))
    else $error("in_ready dropped without an accepted item");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // results of one run stream back to back with rising positions
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_flag |=>
      out_valid && (out_data.position == POS_W'($past(out_data.position) + 1'b1)))
    else $error("merged position did not advance by one");

  // a run that follows the last item directly starts at position zero
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_flag |=>
      !out_valid || (out_data.position == '0))
    else $error("new run did not start at position zero");

  // no new item is taken while a run is still streaming
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_flag |-> !in_ready)
    else $error("input ready during merge output");

endmodule

bind sorted_list_merge_unit slm_chk u_slm_chk (.*);

@@ bench/sorted_list_merge_unit_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_list_merge_unit_tb
// Self-checking bench for the sorted list merge unit. A short table of
// directed items covers the corner cases: empty run, value extremes, ties,
// unsorted lists and the ignored request code. Random load/run batches
// follow, with bursty input and a stalling receiver. Every merged element is
// compared, field by field, against the bench's behavioral merge or a typed row.
// ----------------------------------------------------------------------------
module sorted_list_merge_unit_tb
  import slm_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // request code 3 has no enum member; the block must ignore it
  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
  localparam int unsigned      RAND_ITEMS  = 350;
  localparam int unsigned      MAX_REPORTS = 10;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,   // expectation comes from the bench's merge
    CHK_NONE,    // no result may appear
    CHK_SINGLE   // exactly one typed result: position 0, last set
  } row_check_t;

  typedef struct {
    in_item_t                 item;
    row_check_t               check;
    logic signed [DATA_W-1:0] merged;
  } dir_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // merge state mirrored by the bench
  logic signed [DATA_W-1:0] first_vals  [LIST_DEPTH_DEF];
  logic signed [DATA_W-1:0] second_vals [LIST_DEPTH_DEF];
  int unsigned              first_fill;
  int unsigned              second_fill;

  out_item_t merged_expect [$];
  dir_row_t  dir_rows [$];

  int unsigned mismatches   = 0;
  int unsigned checked      = 0;
  int unsigned runs_done    = 0;
  int unsigned loads_dropped = 0;
  int unsigned ignored_seen = 0;
  int unsigned counted_items = 0;
  int unsigned burst_left   = 0;
  int unsigned stall_left   = 0;
  int unsigned rx_left      = 0;
  int unsigned rx_mode      = 0;

  sorted_list_merge_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Merge predictor. Loads append (dropped once a list is full), code 3 is a
  // no-op, a run fills the merged sequence from the back: the first list's
  // tail wins when >= the second list's tail, so on a tie the first-list
  // element lands later. Leftover first-list elements stay at the front.
  // With emit clear, state advances but nothing is queued (typed rows).
  // --------------------------------------------------------------------------
  task automatic merge_predict(input in_item_t it, input bit emit);
    logic signed [DATA_W-1:0] seqv [2*LIST_DEPTH_DEF];
    int unsigned m;
    int unsigned n;
    int unsigned total;
    out_item_t   res;
    case (it.req_type)
      REQ_LOAD_FIRST: begin
        if (first_fill < LIST_DEPTH_DEF) begin
          first_vals[first_fill] = it.value;
          first_fill++;
        end else begin
          loads_dropped++;
        end
      end
      REQ_LOAD_SECOND: begin
        if (second_fill < LIST_DEPTH_DEF) begin
          second_vals[second_fill] = it.value;
          second_fill++;
        end else begin
          loads_dropped++;
        end
      end
      REQ_RUN: begin
        m     = first_fill;
        n     = second_fill;
        total = m + n;
        for (int p = 0; p < m; p++) seqv[p] = first_vals[p];
        while (n > 0) begin
          if (m > 0 && seqv[m-1] >= second_vals[n-1]) begin
            seqv[m+n-1] = seqv[m-1];
            m--;
          end else begin
            seqv[m+n-1] = second_vals[n-1];
            n--;
          end
        end
        if (emit) begin
          for (int p = 0; p < total; p++) begin
            res.merged_value = seqv[p];
            res.position     = POS_W'(p);
            res.last_flag    = (p + 1 == total);
            merged_expect.push_back(res);
          end
        end
        first_fill  = 0;
        second_fill = 0;
        runs_done++;
      end
      default: ignored_seen++;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sender. Items go out in bursts of random length; between bursts valid
  // drops for a random gap (sometimes not at all). Valid is only lowered at
  // the start of a gap, never in the step where the next item is raised.
  // The prediction is made at the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input bit emit);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    merge_predict(it, emit);
    if (it.req_type != REQ_IGNORED) counted_items++;
  endtask

  // hold the input idle until every queued result has come out
  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (merged_expect.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] val,
                         input row_check_t chk, input logic [DATA_W-1:0] merged);
    dir_row_t r;
    r.item.req_type = req;
    r.item.value    = val;
    r.check         = chk;
    r.merged        = merged;
    dir_rows.push_back(r);
  endtask

  // value generator: full range, a narrow band that forces ties, or the
  // neighborhood of the signed extremes
  function automatic int pick_value(input int unsigned vmode);
    case (vmode)
      1:       return $urandom_range(0, 8) - 4;
      2:       return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                                  : 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // One random batch: loads into both lists in random interleave, usually
  // sorted, then a run. Mostly small lists; now and then one or both lists
  // are filled to depth and beyond so that loads get dropped. A little
  // noise: ignored code-3 items, a missing run, a back-to-back second run.
  // --------------------------------------------------------------------------
  task automatic random_batch();
    int          a [$];
    int          b [$];
    int unsigned m;
    int unsigned n;
    int unsigned vmode;
    int unsigned i;
    int unsigned j;
    int unsigned shape;
    in_item_t    it;
    shape = $urandom_range(0, 15);
    vmode = $urandom_range(0, 3);
    if (shape == 0) begin
      m = $urandom_range(28, 35);
      n = $urandom_range(0, 35);
    end else begin
      m = $urandom_range(0, 6);
      n = $urandom_range(0, 6);
    end
    for (int k = 0; k < m; k++) a.push_back(pick_value(vmode));
    for (int k = 0; k < n; k++) b.push_back(pick_value(vmode));
    if ($urandom_range(0, 9) < 8) begin
      a.sort();
      b.sort();
    end
    i = 0;
    j = 0;
    while (i < m || j < n) begin
      if ($urandom_range(0, 19) == 0) begin
        it.req_type = REQ_IGNORED;
        it.value    = $urandom;
        send_item(it, 1'b1);
      end
      if (j >= n || (i < m && $urandom_range(0, 1) != 0)) begin
        it.req_type = REQ_LOAD_FIRST;
        it.value    = a[i];
        i++;
      end else begin
        it.req_type = REQ_LOAD_SECOND;
        it.value    = b[j];
        j++;
      end
      send_item(it, 1'b1);
    end
    // run value is a don't-care; randomize it anyway
    it.req_type = REQ_RUN;
    it.value    = $urandom;
    if ($urandom_range(0, 9) != 0) send_item(it, 1'b1);
    if ($urandom_range(0, 11) == 0) send_item(it, 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Receiver. Three behaviors that rotate at random intervals: always
  // ready, coin-flip ready, and mostly ready with occasional long stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_left = $urandom_range(40, 200);
      rx_mode = $urandom_range(0, 2);
    end
    rx_left--;
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each accepted item against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (merged_expect.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%t: result with nothing expected: value %0d pos %0d last %0b",
                   $realtime, out_data.merged_value, out_data.position, out_data.last_flag);
        mismatches++;
      end else begin
        want = merged_expect.pop_front();
        checked++;
        if (out_data.merged_value !== want.merged_value ||
            out_data.position !== want.position ||
            out_data.last_flag !== want.last_flag) begin
          if (mismatches < MAX_REPORTS)
            $display("%t: mismatch exp value %0d pos %0d last %0b, got %0d pos %0d last %0b",
                     $realtime, want.merged_value, want.position, want.last_flag,
                     out_data.merged_value, out_data.position, out_data.last_flag);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    out_item_t single;
    int unsigned batches;
    first_fill  = 0;
    second_fill = 0;

    // empty run, then a lone ignored code with every value bit set
    add_row(REQ_RUN,         32'h0000_0000, CHK_NONE,   '0);
    add_row(REQ_IGNORED,     32'hffff_ffff, CHK_NONE,   '0);
    // extremes through a one-element run from each list
    add_row(REQ_LOAD_FIRST,  32'h7fff_ffff, CHK_NONE,   '0);
    add_row(REQ_RUN,         32'hffff_ffff, CHK_SINGLE, 32'h7fff_ffff);
    add_row(REQ_LOAD_SECOND, 32'h8000_0000, CHK_NONE,   '0);
    add_row(REQ_RUN,         32'h0000_0000, CHK_SINGLE, 32'h8000_0000);
    // ties between lists and both extremes mixed in
    add_row(REQ_LOAD_FIRST,  -32'sd10,      CHK_MODEL,  '0);
    add_row(REQ_LOAD_FIRST,  32'sd5,        CHK_MODEL,  '0);
    add_row(REQ_LOAD_SECOND, -32'sd10,      CHK_MODEL,  '0);
    add_row(REQ_LOAD_SECOND, 32'sd5,        CHK_MODEL,  '0);
    add_row(REQ_LOAD_SECOND, 32'h7fff_ffff, CHK_MODEL,  '0);
    add_row(REQ_LOAD_FIRST,  32'h8000_0000, CHK_MODEL,  '0);
    add_row(REQ_RUN,         32'h0000_0000, CHK_MODEL,  '0);
    // unsorted contents
    add_row(REQ_LOAD_FIRST,  32'sd9,        CHK_MODEL,  '0);
    add_row(REQ_LOAD_FIRST,  32'sd1,        CHK_MODEL,  '0);
    add_row(REQ_LOAD_SECOND, 32'sd4,        CHK_MODEL,  '0);
    add_row(REQ_LOAD_SECOND, 32'sd3,        CHK_MODEL,  '0);
    add_row(REQ_RUN,         32'h0000_0000, CHK_MODEL,  '0);
    // first list only, with an ignored code in the middle
    add_row(REQ_LOAD_FIRST,  32'sd1,        CHK_MODEL,  '0);
    add_row(REQ_IGNORED,     32'h5555_aaaa, CHK_MODEL,  '0);
    add_row(REQ_LOAD_FIRST,  32'sd2,        CHK_MODEL,  '0);
    add_row(REQ_RUN,         32'h0000_0000, CHK_MODEL,  '0);

    // synchronous reset, held low from time zero
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].item, dir_rows[k].check == CHK_MODEL);
      if (dir_rows[k].check == CHK_SINGLE) begin
        single.merged_value = dir_rows[k].merged;
        single.position     = '0;
        single.last_flag    = 1'b1;
        merged_expect.push_back(single);
      end
    end

    counted_items = 0;
    batches       = 0;
    while (counted_items < RAND_ITEMS) begin
      random_batch();
      batches++;
      // full hold-off once early on, then now and again
      if (batches == 6 || $urandom_range(0, 14) == 0) drain_results();
    end
    // flush whatever the last batch left loaded
    send_item('{req_type: REQ_RUN, value: '0}, 1'b1);

    drain_results();
    repeat (150) @(posedge clk);

    $display("Covered %0d merge runs and %0d checked elements over %0d random items,",
             runs_done, checked, counted_items);
    $display("with %0d loads dropped on full lists and %0d code-3 items ignored.",
             loads_dropped, ignored_seen);
    if (mismatches == 0 && merged_expect.size() == 0) begin
      $display("sorted_list_merge_unit verification clean");
    end else begin
      $display("sorted_list_merge_unit verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", merged_expect.size());
    $display("sorted_list_merge_unit verification failed");
    $finish;
  end

endmodule
